// ===== hw/rtl/fibonacci_matrix_power_macros.svh =====
// assertion macros shared by the fibonacci matrix power checker
`ifndef FIBONACCI_MATRIX_POWER_MACROS_SVH
`define FIBONACCI_MATRIX_POWER_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define FMP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fibonacci_matrix_power: same-cycle check failed");

// next-cycle implication, sampled on the block clock, off during reset
`define FMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fibonacci_matrix_power: next-cycle check failed");

`endif

// ===== hw/rtl/fmp_pkg.sv =====
// package: constants and elaboration helpers for the fibonacci matrix power block
`timescale 1ns / 1ps

package fmp_pkg;

    // default widths
    localparam int DEF_INDEX_BITS = 8;
    localparam int DEF_VALUE_BITS = 64;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // largest k whose fibonacci number fits a signed vb-bit value
    function automatic logic [63:0] max_safe_index(input int vb);
        logic [63:0] limit;
        logic [63:0] prev;
        logic [63:0] cur;
        logic [63:0] nx;
        logic [63:0] k;
        limit = (64'hFFFF_FFFF_FFFF_FFFF >> (64 - vb)) >> 1;
        prev  = 64'd1;
        cur   = 64'd1;
        k     = 64'd2;
        while (prev + cur <= limit) begin
            nx   = prev + cur;
            prev = cur;
            cur  = nx;
            k    = k + 64'd1;
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/fibonacci_matrix_power.sv =====
// top level: fibonacci number by 2x2 matrix square-and-multiply on one shared multiplier
//
//   channel   direction  ports                      handshake
//   command   in         i_start, i_index           taken when i_start && !o_busy
//   result    out        o_done, o_value, o_status  one-cycle strobe o_done
//
// index 0, 1 and 2 answer in the cycle after the transaction, busy stays low.
// larger indices keep busy high while matrix products run; each product
// is four scalar terms, each term three half-width partial products through the one
// multiplier, then the drain and commit states.
// reset is synchronous active low and clears the sequencer and the strobe.
// the receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module fibonacci_matrix_power
    import fmp_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [INDEX_BITS-1:0] i_index,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [1:0]            o_status
);

    localparam int HW = (VALUE_BITS + 1) / 2;
    localparam int PW = 2 * HW;
    localparam logic [63:0] MAX_SAFE = max_safe_index(VALUE_BITS);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STEP   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    // scalar terms of one symmetric matrix product
    localparam logic [1:0] K_AB = 2'd0;  // x.a * y.b  into b
    localparam logic [1:0] K_BC = 2'd1;  // x.b * y.c  into b
    localparam logic [1:0] K_BB = 2'd2;  // x.b * y.b  into c
    localparam logic [1:0] K_CC = 2'd3;  // x.c * y.c  into c

    // partial products of one term
    localparam logic [1:0] Q_LL = 2'd0;
    localparam logic [1:0] Q_LH = 2'd1;
    localparam logic [1:0] Q_HL = 2'd2;

    logic [2:0]            r_state, n_state;
    logic                  r_done;
    logic                  r_pv;
    logic                  r_sel_acc;
    logic [1:0]            r_k, r_q, r_pk, r_pq;
    logic [INDEX_BITS-1:0] r_e;
    logic                  r_ovf;
    logic [VALUE_BITS-1:0] r_value;
    logic [1:0]            r_status;

    // matrices kept as [[a,b],[b,c]]
    logic [VALUE_BITS-1:0] r_acc_a, r_acc_b, r_acc_c;
    logic [VALUE_BITS-1:0] r_bas_a, r_bas_b, r_bas_c;
    logic [VALUE_BITS-1:0] r_sb, r_sc;
    logic [PW-1:0]         r_prod;

    logic                  w_accept;
    logic [VALUE_BITS-1:0] w_xa, w_xb, w_xc;
    logic [VALUE_BITS-1:0] w_xs, w_ys;
    logic [PW-1:0]         w_xe, w_ye;
    logic [HW-1:0]         w_op1, w_op2;
    logic [PW-1:0]         w_term;
    logic                  w_more;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_more   = r_sel_acc && (r_e[INDEX_BITS-1:1] != '0);

    // left operand: accumulator or base, right operand always base
    assign w_xa = r_sel_acc ? r_acc_a : r_bas_a;
    assign w_xb = r_sel_acc ? r_acc_b : r_bas_b;
    assign w_xc = r_sel_acc ? r_acc_c : r_bas_c;

    // scalar pick for the current term
    always_comb begin
        case (r_k)
            K_AB:    begin w_xs = w_xa; w_ys = r_bas_b; end
            K_BC:    begin w_xs = w_xb; w_ys = r_bas_c; end
            K_BB:    begin w_xs = w_xb; w_ys = r_bas_b; end
            default: begin w_xs = w_xc; w_ys = r_bas_c; end
        endcase
    end

    // half-word pick for the current partial product
    assign w_xe = PW'(w_xs);
    assign w_ye = PW'(w_ys);
    always_comb begin
        case (r_q)
            Q_LL:    begin w_op1 = w_xe[HW-1:0];  w_op2 = w_ye[HW-1:0];  end
            Q_LH:    begin w_op1 = w_xe[HW-1:0];  w_op2 = w_ye[PW-1:HW]; end
            default: begin w_op1 = w_xe[PW-1:HW]; w_op2 = w_ye[HW-1:0];  end
        endcase
    end

    // cross products land one half-word up
    assign w_term = (r_pq == Q_LL) ? r_prod : {r_prod[HW-1:0], {HW{1'b0}}};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_index > INDEX_BITS'(2))) n_state = S_STEP;
            end
            S_STEP: begin
                n_state = (r_e == '0) ? S_FIN : S_MUL;
            end
            S_MUL: begin
                if ((r_q == Q_HL) && (r_k == K_CC)) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_COMMIT;
            S_COMMIT: n_state = w_more ? S_MUL : S_STEP;
            S_FIN:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_MUL);
            r_done  <= (w_accept && (i_index <= INDEX_BITS'(2))) || (r_state == S_FIN);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // shared multiplier, registered
        r_prod <= PW'(w_op1) * PW'(w_op2);
        r_pk   <= r_k;
        r_pq   <= r_q;

        // accumulate the previous partial product
        if (r_pv) begin
            if ((r_pk == K_AB) || (r_pk == K_BC)) r_sb <= r_sb + w_term[VALUE_BITS-1:0];
            else                                  r_sc <= r_sc + w_term[VALUE_BITS-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_acc_a  <= VALUE_BITS'(1);
                    r_acc_b  <= '0;
                    r_acc_c  <= VALUE_BITS'(1);
                    r_bas_a  <= VALUE_BITS'(1);
                    r_bas_b  <= VALUE_BITS'(1);
                    r_bas_c  <= '0;
                    r_sb     <= '0;
                    r_sc     <= '0;
                    r_e      <= i_index - INDEX_BITS'(2);
                    r_ovf    <= (64'(i_index) > MAX_SAFE);
                    r_value  <= (i_index == '0) ? '0 : VALUE_BITS'(1);
                    r_status <= (i_index == '0) ? ST_INVALID : ST_OK;
                end
            end
            S_STEP: begin
                r_sel_acc <= r_e[0];
                r_k       <= K_AB;
                r_q       <= Q_LL;
            end
            S_MUL: begin
                if (r_q == Q_HL) begin
                    r_q <= Q_LL;
                    r_k <= r_k + 2'd1;
                end else begin
                    r_q <= r_q + 2'd1;
                end
            end
            S_DRAIN: begin
            end
            S_COMMIT: begin
                if (r_sel_acc) begin
                    r_acc_a <= r_sb + r_sc;
                    r_acc_b <= r_sb;
                    r_acc_c <= r_sc;
                end else begin
                    r_bas_a <= r_sb + r_sc;
                    r_bas_b <= r_sb;
                    r_bas_c <= r_sc;
                end
                r_sb <= '0;
                r_sc <= '0;
                r_k  <= K_AB;
                r_q  <= Q_LL;
                if (w_more) r_sel_acc <= 1'b0;
                else        r_e       <= r_e >> 1;
            end
            S_FIN: begin
                r_value  <= r_acc_a + r_acc_b;
                r_status <= r_ovf ? ST_OVERFLOW : ST_OK;
            end
            default: begin
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

// ===== hw/rtl/fmp_checker.sv =====
// port checker for the fibonacci matrix power block, bound to the top level
`timescale 1ns / 1ps
`include "fibonacci_matrix_power_macros.svh"

module fmp_checker
    import fmp_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_start,
    input logic [INDEX_BITS-1:0] i_index,
    input logic                  o_busy,
    input logic                  o_done,
    input logic [VALUE_BITS-1:0] o_value,
    input logic [1:0]            o_status
);

    logic w_take;
    assign w_take = i_start && !o_busy;

    // an invalid index always reports a zero value
    `FMP_ASSERT_NOW(a_invalid_zero, o_done && (o_status == ST_INVALID), o_value == '0)
    // only the three defined status codes appear
    `FMP_ASSERT_NOW(a_status_code, o_done, (o_status == ST_OK) || (o_status == ST_INVALID) || (o_status == ST_OVERFLOW))
    // index zero answers invalid in the next cycle
    `FMP_ASSERT_NEXT(a_zero_fast, w_take && (i_index == '0),
                     o_done && (o_status == ST_INVALID))
    // index one or two answers one in the next cycle
    `FMP_ASSERT_NEXT(a_small_fast,
                     w_take && ((i_index == INDEX_BITS'(1)) || (i_index == INDEX_BITS'(2))),
                     o_done && (o_value == VALUE_BITS'(1)) && (o_status == ST_OK))
    // a larger index makes the block busy with no result yet
    `FMP_ASSERT_NEXT(a_large_busy, w_take && (i_index > INDEX_BITS'(2)), o_busy && !o_done)

endmodule

bind fibonacci_matrix_power fmp_checker #(
    .INDEX_BITS(INDEX_BITS),
    .VALUE_BITS(VALUE_BITS)
) u_fmp_checker (.*);
